>>> src/vrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

  localparam int MaxAreasDefault  = 16;
  localparam int PageShiftDefault = 12;

  localparam int AddrW   = 48;
  localparam int PermW   = 3;
  localparam int StatusW = 3;
  localparam int ReqW    = 2;

  localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqW-1:0] REQ_REMOVE = 2'd1;
  localparam logic [ReqW-1:0] REQ_LOOKUP = 2'd2;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [StatusW-1:0] ST_DONE     = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_HIT      = 3'd3;
  localparam logic [StatusW-1:0] ST_SEGV     = 3'd4;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] phys;
    logic [AddrW-1:0] length;
    logic [PermW-1:0] perms;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
    logic clr_all;
  } store_cmd_t;

endpackage

`default_nettype wire

>>> src/vrt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vrt_req_if;
  logic                       valid;
  logic                       ready;
  logic [vrt_pkg::ReqW-1:0]   req_type;
  logic [vrt_pkg::AddrW-1:0]  virt_addr;
  logic [vrt_pkg::AddrW-1:0]  phys_base;
  logic [vrt_pkg::AddrW-1:0]  region_size;
  logic [vrt_pkg::PermW-1:0]  perm_flags;

  modport source (
    output valid, req_type, virt_addr, phys_base, region_size, perm_flags,
    input  ready
  );
  modport sink (
    input  valid, req_type, virt_addr, phys_base, region_size, perm_flags,
    output ready
  );
endinterface

`default_nettype wire

>>> src/vrt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface vrt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vrt_pkg::StatusW-1:0]  status;
  logic [vrt_pkg::AddrW-1:0]    page_virt;
  logic [vrt_pkg::AddrW-1:0]    page_phys;
  logic                         no_execute;
  logic                         read_only;
  logic                         user_grant;

  modport source (
    output valid, status, page_virt, page_phys, no_execute, read_only, user_grant,
    input  ready
  );
  modport sink (
    input  valid, status, page_virt, page_phys, no_execute, read_only, user_grant,
    output ready
  );
endinterface

`default_nettype wire

>>> src/vrt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module vrt_store #(
  parameter int MAX_AREAS = 16
) (
  input  wire                                                clk,
  input  wire                                                rst,
  input  vrt_pkg::store_cmd_t                                cmd,
  input  wire [((MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1)-1:0] rd_addr,
  input  wire [((MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1)-1:0] wr_addr,
  input  vrt_pkg::entry_t                                    wr_data,
  output vrt_pkg::entry_t                                    rd_entry,
  output logic                                               rd_vld
);
  import vrt_pkg::*;

  logic [MAX_AREAS-1:0] valid;
  entry_t               mem [MAX_AREAS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clr_all) begin
      valid <= '0;
    end else begin
      if (cmd.set_valid) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.clr_valid) begin
        valid[wr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (cmd.rd_en) begin
      rd_vld <= valid[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/vrt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vrt_ctrl #(
  parameter int MAX_AREAS  = 16,
  parameter int PAGE_SHIFT = 12
) (
  input  wire                                                 clk,
  input  wire                                                 rst,
  vrt_req_if.sink                                             req,
  vrt_rsp_if.source                                           rsp,
  output vrt_pkg::store_cmd_t                                 cmd,
  output logic [((MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1)-1:0] rd_addr,
  output logic [((MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1)-1:0] wr_addr,
  output vrt_pkg::entry_t                                     wr_data,
  input  vrt_pkg::entry_t                                     rd_entry,
  input  wire                                                 rd_vld
);
  import vrt_pkg::*;

  localparam int IdxW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int CntW = $clog2(MAX_AREAS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_AREAS);
  localparam logic [AddrW-1:0] PageMask =
    {{(AddrW - PAGE_SHIFT){1'b1}}, {PAGE_SHIFT{1'b0}}};

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state;
  logic [ReqW-1:0]  op;
  logic [AddrW-1:0] va;
  logic [AddrW-1:0] pa;
  logic [AddrW-1:0] len;
  logic [PermW-1:0] perm;
  logic [CntW-1:0]  iss_cnt;

  logic             p1_v;
  logic [IdxW-1:0]  p1_idx;
  logic             p2_v;
  logic             p2_hit;
  logic [IdxW-1:0]  p2_idx;
  logic [AddrW-1:0] p2_start;
  logic [AddrW-1:0] p2_delta;
  logic [PermW-1:0] p2_perm;

  logic             found;
  logic [IdxW-1:0]  sel_idx;
  logic             best_v;
  logic [AddrW-1:0] best_start;
  logic [AddrW-1:0] best_delta;
  logic [PermW-1:0] best_perm;

  logic [StatusW-1:0] out_status;
  logic [AddrW-1:0]   out_virt;
  logic [AddrW-1:0]   out_phys;
  logic               out_nx;
  logic               out_ro;
  logic               out_user;
  logic               out_valid;

  logic             accept;
  logic             issue;
  logic             take;
  logic             scan_end;
  logic             fin_fire;
  logic             eval_hit;
  logic [AddrW:0]   diff;
  logic [AddrW-1:0] page_v;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign issue     = (state == S_SCAN) && (iss_cnt != CntMax);
  assign take      = (state == S_SCAN) && p2_v && p2_hit && (op != REQ_LOOKUP);
  assign scan_end  = (state == S_SCAN) && (iss_cnt == CntMax) && !p1_v && !p2_v;
  assign fin_fire  = (state == S_FINISH) && (!out_valid || rsp.ready);
  assign page_v    = va & PageMask;

  always_comb begin
    diff = {1'b0, va} - {1'b0, rd_entry.start};
    case (op)
      REQ_INSERT: eval_hit = !rd_vld;
      REQ_REMOVE: eval_hit = rd_vld && (rd_entry.start == va);
      REQ_LOOKUP: eval_hit = rd_vld && !diff[AddrW] && (diff[AddrW-1:0] < rd_entry.length);
      default:    eval_hit = 1'b0;
    endcase
  end

  always_comb begin
    cmd.rd_en     = issue;
    cmd.wr_en     = fin_fire && (op == REQ_INSERT) && found;
    cmd.set_valid = fin_fire && (op == REQ_INSERT) && found;
    cmd.clr_valid = fin_fire && (op == REQ_REMOVE) && found;
    cmd.clr_all   = fin_fire && (op == REQ_CLEAR);
    rd_addr       = iss_cnt[IdxW-1:0];
    wr_addr       = sel_idx;
    wr_data.start  = va;
    wr_data.phys   = pa;
    wr_data.length = len;
    wr_data.perms  = perm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v && (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (req.req_type == REQ_CLEAR) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (take || scan_end) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= req.req_type;
      va      <= req.virt_addr;
      pa      <= req.phys_base;
      len     <= req.region_size;
      perm    <= req.perm_flags;
      iss_cnt <= '0;
      found   <= 1'b0;
      best_v  <= 1'b0;
    end else begin
      if (issue) begin
        iss_cnt <= iss_cnt + 1'b1;
      end
      if (take) begin
        found   <= 1'b1;
        sel_idx <= p2_idx;
      end
      if ((state == S_SCAN) && p2_v && p2_hit && (op == REQ_LOOKUP) &&
          (!best_v || (p2_start < best_start))) begin
        best_v     <= 1'b1;
        best_start <= p2_start;
        best_delta <= p2_delta;
        best_perm  <= p2_perm;
      end
    end
    p1_idx   <= iss_cnt[IdxW-1:0];
    p2_hit   <= eval_hit;
    p2_idx   <= p1_idx;
    p2_start <= rd_entry.start;
    p2_delta <= rd_entry.phys - rd_entry.start;
    p2_perm  <= rd_entry.perms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_virt <= '0;
      out_phys <= '0;
      out_nx   <= 1'b0;
      out_ro   <= 1'b0;
      out_user <= 1'b0;
      case (op)
        REQ_INSERT: out_status <= found ? ST_DONE : ST_FULL;
        REQ_REMOVE: out_status <= found ? ST_DONE : ST_NOTFOUND;
        REQ_LOOKUP: begin
          if (best_v) begin
            out_status <= ST_HIT;
            out_virt   <= page_v;
            out_phys   <= (best_delta + page_v) & PageMask;
            out_nx     <= !best_perm[2];
            out_ro     <= !best_perm[1];
            out_user   <= best_perm[0];
          end else begin
            out_status <= ST_SEGV;
          end
        end
        default: out_status <= ST_DONE;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.page_virt  = out_virt;
  assign rsp.page_phys  = out_phys;
  assign rsp.no_execute = out_nx;
  assign rsp.read_only  = out_ro;
  assign rsp.user_grant = out_user;

endmodule

`default_nettype wire

>>> src/vma_region_table_top.sv
// A request is taken only while idle; the scan then reads the slots in order through
// the store read register and the compare registers. A lookup, a full-table insert
// or an unmatched remove scans every slot; an insert or remove that stops at slot k
// ends its scan there. The next request is taken once the result is registered; the
// scan reads one table entry per cycle. A clear skips the scan and goes to finish.
// Reset: synchronous active-high rst empties the table and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module vma_region_table_top #(
  parameter int MAX_AREAS  = vrt_pkg::MaxAreasDefault,
  parameter int PAGE_SHIFT = vrt_pkg::PageShiftDefault
) (
  input  wire        clk,
  input  wire        rst,
  vrt_req_if.sink    req,
  vrt_rsp_if.source  rsp
);
  import vrt_pkg::*;

  localparam int IdxW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;

  store_cmd_t      cmd;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  entry_t          rd_entry;
  logic            rd_vld;

  vrt_ctrl #(
    .MAX_AREAS  (MAX_AREAS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_entry (rd_entry),
    .rd_vld   (rd_vld)
  );

  vrt_store #(
    .MAX_AREAS (MAX_AREAS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_entry (rd_entry),
    .rd_vld   (rd_vld)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("A second request was taken while one was in progress.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_HIT)) |->
      ((rsp.page_virt == '0) && (rsp.page_phys == '0) && !rsp.no_execute &&
       !rsp.read_only && !rsp.user_grant))
    else $error("A result other than a hit carries nonzero page fields.");

  a_hit_aligned: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_HIT)) |->
      ((rsp.page_virt[PAGE_SHIFT-1:0] == '0) && (rsp.page_phys[PAGE_SHIFT-1:0] == '0)))
    else $error("A hit returned a page address that is not page aligned.");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !(cmd.wr_en || cmd.set_valid || cmd.clr_valid || cmd.clr_all))
    else $error("The table was written while a scan was reading it.");
`endif

endmodule

`default_nettype wire
